[rtl/cpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared widths, operation codes, controller states and the frame memory
// write-enable group for the clock page replacer.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // Fixed transaction field widths
    localparam int FUNC_W      = 2;
    localparam int FRAME_NUM_W = 6;
    localparam int RING_SIZE_W = 7;

    // Default number of frames tracked by the replacer
    localparam int NUM_FRAMES_DEF = 64;

    // Operation codes carried in func; the fourth code is unused
    localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LINK_NEXT,
        ST_LINK_PREV,
        ST_UNPIN_WR,
        ST_FINISH
    } cpr_state_t;

    // Per-field write enables of one frame memory entry
    typedef struct packed {
        logic flags;
        logic next;
        logic prev;
    } mem_we_t;

endpackage : cpr_pkg
`default_nettype wire

[rtl/cpr_frame_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_frame_mem
// Frame table: membership and reference flags plus ring links, one entry per
// frame. One read port with registered data, one write port with per-field
// enables; a write to the entry being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module cpr_frame_mem #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_en,
    input  wire [$clog2(NUM_FRAMES)-1:0] rd_addr,
    input  cpr_pkg::mem_we_t             wr_en,
    input  wire [$clog2(NUM_FRAMES)-1:0] wr_addr,
    input  wire                          wr_in_ring,
    input  wire                          wr_ref,
    input  wire [$clog2(NUM_FRAMES)-1:0] wr_next,
    input  wire [$clog2(NUM_FRAMES)-1:0] wr_prev,
    output logic                         rd_in_ring,
    output logic                         rd_ref,
    output logic [$clog2(NUM_FRAMES)-1:0] rd_next,
    output logic [$clog2(NUM_FRAMES)-1:0] rd_prev
);
    import cpr_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int EW = 2 + 2 * FW;

    // Entry layout: in_ring, ref, next link, prev link
    logic [EW-1:0] mem [NUM_FRAMES];

    logic [EW-1:0] raw_reg;
    mem_we_t       fwd_reg;
    logic          fwd_in_reg;
    logic          fwd_ref_reg;
    logic [FW-1:0] fwd_next_reg;
    logic [FW-1:0] fwd_prev_reg;

    logic          same_addr;

    assign same_addr = rd_en && (rd_addr == wr_addr);

    // Write the enabled fields of one entry
    always_ff @(posedge clk)
    begin
        if (wr_en.flags)
        begin
            mem[wr_addr][EW-1:EW-2] <= {wr_in_ring, wr_ref};
        end
        if (wr_en.next)
        begin
            mem[wr_addr][2*FW-1:FW] <= wr_next;
        end
        if (wr_en.prev)
        begin
            mem[wr_addr][FW-1:0] <= wr_prev;
        end
    end

    // Register the read word and the write data that overlaps it
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raw_reg      <= mem[rd_addr];
            fwd_in_reg   <= wr_in_ring;
            fwd_ref_reg  <= wr_ref;
            fwd_next_reg <= wr_next;
            fwd_prev_reg <= wr_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
        end
        else if (rd_en)
        begin
            fwd_reg <= same_addr ? wr_en : '0;
        end
    end

    // Merge forwarded fields over the stored word
    always_comb
    begin
        rd_in_ring = fwd_reg.flags ? fwd_in_reg   : raw_reg[EW-1];
        rd_ref     = fwd_reg.flags ? fwd_ref_reg  : raw_reg[EW-2];
        rd_next    = fwd_reg.next  ? fwd_next_reg : raw_reg[2*FW-1:FW];
        rd_prev    = fwd_reg.prev  ? fwd_prev_reg : raw_reg[FW-1:0];
    end

endmodule : cpr_frame_mem
`default_nettype wire

[rtl/cpr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer of the clock replacer: holds head, tail, hand and count, walks
// the frame table for pin, unpin and victim sweeps, and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module cpr_ctrl #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // request channel
    input  wire                              req_valid,
    output logic                             req_stall,
    input  wire [cpr_pkg::FUNC_W-1:0]        func,
    input  wire [cpr_pkg::FRAME_NUM_W-1:0]   frame_num,
    // response channel
    output logic                             rsp_valid,
    input  wire                              rsp_stall,
    output logic                             victim_found,
    output logic [cpr_pkg::FRAME_NUM_W-1:0]  victim_frame,
    output logic [cpr_pkg::RING_SIZE_W-1:0]  ring_size,
    // frame memory
    output logic                             mem_rd_en,
    output logic [$clog2(NUM_FRAMES)-1:0]    mem_rd_addr,
    output cpr_pkg::mem_we_t                 mem_wr_en,
    output logic [$clog2(NUM_FRAMES)-1:0]    mem_wr_addr,
    output logic                             mem_wr_in_ring,
    output logic                             mem_wr_ref,
    output logic [$clog2(NUM_FRAMES)-1:0]    mem_wr_next,
    output logic [$clog2(NUM_FRAMES)-1:0]    mem_wr_prev,
    input  wire                              mem_rd_in_ring,
    input  wire                              mem_rd_ref,
    input  wire [$clog2(NUM_FRAMES)-1:0]     mem_rd_next,
    input  wire [$clog2(NUM_FRAMES)-1:0]     mem_rd_prev
);
    import cpr_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [FW-1:0] CLR_LAST = FW'(NUM_FRAMES - 1);

    cpr_state_t          state_reg, state_next;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [FW-1:0]       frame_reg, frame_next;
    logic [FW-1:0]       head_reg, head_next;
    logic [FW-1:0]       tail_reg, tail_next;
    logic [FW-1:0]       hand_reg, hand_next;
    logic                at_end_reg, at_end_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FW-1:0]       nx_reg, nx_next;
    logic [FW-1:0]       pv_reg, pv_next;
    logic                found_reg, found_next;
    logic [FW-1:0]       clr_reg, clr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rsp_found_reg, rsp_found_next;
    logic [FRAME_NUM_W-1:0] rsp_frame_reg, rsp_frame_next;
    logic [RING_SIZE_W-1:0] rsp_size_reg, rsp_size_next;

    logic          accept;
    logic          in_range;
    logic [FW-1:0] req_frame;
    logic [FW-1:0] start_hand;
    logic [FW-1:0] sweep_hand;
    logic          is_head;
    logic          is_tail;
    logic          middle;
    logic          drop;
    logic          rsp_free;

    assign accept     = req_valid && !req_stall;
    assign in_range   = int'(frame_num) < NUM_FRAMES;
    assign req_frame  = FW'(frame_num);
    assign start_hand = at_end_reg ? head_reg : hand_reg;
    assign sweep_hand = (tail_reg == frame_reg) ? head_reg : mem_rd_next;
    assign is_head    = (head_reg == frame_reg);
    assign is_tail    = (tail_reg == frame_reg);
    assign middle     = !is_head && !is_tail;
    assign drop       = ((op_reg == FUNC_VICTIM) && !mem_rd_ref)
                     || ((op_reg == FUNC_PIN) && mem_rd_in_ring);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign victim_found = rsp_found_reg;
    assign victim_frame = rsp_frame_reg;
    assign ring_size    = rsp_size_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func) inside
                        FUNC_VICTIM:
                        begin
                            state_next = (count_reg == '0) ? ST_FINISH : ST_CHECK;
                        end
                        FUNC_PIN, FUNC_UNPIN:
                        begin
                            state_next = in_range ? ST_CHECK : ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (drop)
                begin
                    state_next = middle ? ST_LINK_NEXT : ST_FINISH;
                end
                else if (op_reg == FUNC_VICTIM)
                begin
                    state_next = ST_CHECK;
                end
                else if ((op_reg == FUNC_UNPIN) && !mem_rd_in_ring)
                begin
                    state_next = ST_UNPIN_WR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LINK_NEXT:
            begin
                state_next = ST_LINK_PREV;
            end
            ST_LINK_PREV:
            begin
                state_next = ST_FINISH;
            end
            ST_UNPIN_WR:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory ports and result register
    always_comb
    begin
        op_next        = op_reg;
        frame_next     = frame_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        hand_next      = hand_reg;
        at_end_next    = at_end_reg;
        count_next     = count_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        found_next     = found_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_found_next = rsp_found_reg;
        rsp_frame_next = rsp_frame_reg;
        rsp_size_next  = rsp_size_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = '0;
        mem_wr_addr    = '0;
        mem_wr_in_ring = 1'b0;
        mem_wr_ref     = 1'b0;
        mem_wr_next    = '0;
        mem_wr_prev    = '0;

        // Drop a delivered result
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = '{flags: 1'b1, next: 1'b1, prev: 1'b1};
                mem_wr_addr = clr_reg;
                clr_next    = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = func;
                    found_next = 1'b0;
                    frame_next = req_frame;
                    if (func == FUNC_VICTIM)
                    begin
                        // Wrap a parked hand to the head and read its entry
                        if (count_reg != '0)
                        begin
                            hand_next   = start_hand;
                            at_end_next = 1'b0;
                            frame_next  = start_hand;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = start_hand;
                        end
                    end
                    else
                    begin
                        mem_rd_en   = in_range;
                        mem_rd_addr = req_frame;
                    end
                end
            end
            ST_CHECK:
            begin
                if (drop)
                begin
                    // Unlink the frame; step the hand off it first
                    mem_wr_en.flags = 1'b1;
                    mem_wr_addr     = frame_reg;
                    nx_next         = mem_rd_next;
                    pv_next         = mem_rd_prev;
                    count_next      = count_reg - 1'b1;
                    if (op_reg == FUNC_VICTIM)
                    begin
                        found_next = 1'b1;
                    end
                    if (!at_end_reg && (hand_reg == frame_reg))
                    begin
                        if (is_tail)
                        begin
                            at_end_next = 1'b1;
                        end
                        else
                        begin
                            hand_next = mem_rd_next;
                        end
                    end
                    if (is_head && is_tail)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (is_head)
                    begin
                        head_next = mem_rd_next;
                    end
                    else if (is_tail)
                    begin
                        tail_next = mem_rd_prev;
                    end
                end
                else if (op_reg == FUNC_VICTIM)
                begin
                    // Give a second chance and advance the hand
                    mem_wr_en.flags = 1'b1;
                    mem_wr_addr     = frame_reg;
                    mem_wr_in_ring  = 1'b1;
                    mem_wr_ref      = 1'b0;
                    hand_next       = sweep_hand;
                    frame_next      = sweep_hand;
                    mem_rd_en       = 1'b1;
                    mem_rd_addr     = sweep_hand;
                end
                else if (op_reg == FUNC_UNPIN)
                begin
                    if (mem_rd_in_ring)
                    begin
                        mem_wr_en.flags = 1'b1;
                        mem_wr_addr     = frame_reg;
                        mem_wr_in_ring  = 1'b1;
                        mem_wr_ref      = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        // Link the old tail forward to the new frame
                        mem_wr_en.next = 1'b1;
                        mem_wr_addr    = tail_reg;
                        mem_wr_next    = frame_reg;
                    end
                end
            end
            ST_LINK_NEXT:
            begin
                mem_wr_en.next = 1'b1;
                mem_wr_addr    = pv_reg;
                mem_wr_next    = nx_reg;
            end
            ST_LINK_PREV:
            begin
                mem_wr_en.prev = 1'b1;
                mem_wr_addr    = nx_reg;
                mem_wr_prev    = pv_reg;
            end
            ST_UNPIN_WR:
            begin
                mem_wr_en.flags = 1'b1;
                mem_wr_en.prev  = 1'b1;
                mem_wr_addr     = frame_reg;
                mem_wr_in_ring  = 1'b1;
                mem_wr_ref      = 1'b1;
                mem_wr_prev     = tail_reg;
                tail_next       = frame_reg;
                count_next      = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    head_next = frame_reg;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = found_reg;
                    rsp_frame_next = found_reg ? FRAME_NUM_W'(frame_reg) : '0;
                    rsp_size_next  = RING_SIZE_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            hand_reg      <= '0;
            at_end_reg    <= 1'b1;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            op_reg        <= FUNC_VICTIM;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            hand_reg      <= hand_next;
            at_end_reg    <= at_end_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        nx_reg        <= nx_next;
        pv_reg        <= pv_next;
        rsp_found_reg <= rsp_found_next;
        rsp_frame_reg <= rsp_frame_next;
        rsp_size_reg  <= rsp_size_next;
    end

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start");

    // The ring never holds more entries than frames exist
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= NUM_FRAMES)
        else $error("ring count above frame count");

    // A single entry is both head and tail
    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(1)) |-> (head_reg == tail_reg))
        else $error("head and tail differ on a one-entry ring");

    // A victim request on an empty ring finishes at once with nothing found
    a_empty_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_VICTIM) && (count_reg == '0))
            |=> ((state_reg == ST_FINISH) && !found_reg))
        else $error("victim on empty ring did not report not found");

endmodule : cpr_ctrl
`default_nettype wire

[rtl/clock_page_replacer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacer_top
// Second-chance clock replacer over a ring of evictable frames kept in
// insertion order; frame table in a synchronous memory, sequenced by cpr_ctrl.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  func, frame_num
//   response  out        rsp_valid/rsp_stall  victim_found, victim_frame, ring_size
//
// Transactions: one at a time. Pin takes two extra link writes when a middle
// entry is unlinked. Victim reads the frames the hand inspects, at most two
// ring passes, through the single read port of the frame memory, plus the
// same two link writes when it unlinks a middle entry.
// Reset: after reset the frame memory is swept clear, entry by entry;
// req_stall stays high during the sweep.
// Stalls: a finished result waits in the output register while the next
// transaction is accepted; the controller holds in its last step only when
// a new result is ready and the previous one is still stalled.
// ----------------------------------------------------------------------------
module clock_page_replacer_top #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              req_valid,
    output logic                             req_stall,
    input  wire [cpr_pkg::FUNC_W-1:0]        func,
    input  wire [cpr_pkg::FRAME_NUM_W-1:0]   frame_num,
    output logic                             rsp_valid,
    input  wire                              rsp_stall,
    output logic                             victim_found,
    output logic [cpr_pkg::FRAME_NUM_W-1:0]  victim_frame,
    output logic [cpr_pkg::RING_SIZE_W-1:0]  ring_size
);
    import cpr_pkg::*;

    localparam int FW = $clog2(NUM_FRAMES);

    logic          mem_rd_en;
    logic [FW-1:0] mem_rd_addr;
    mem_we_t       mem_wr_en;
    logic [FW-1:0] mem_wr_addr;
    logic          mem_wr_in_ring;
    logic          mem_wr_ref;
    logic [FW-1:0] mem_wr_next;
    logic [FW-1:0] mem_wr_prev;
    logic          mem_rd_in_ring;
    logic          mem_rd_ref;
    logic [FW-1:0] mem_rd_next;
    logic [FW-1:0] mem_rd_prev;

    // Sequencer
    cpr_ctrl #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .frame_num      (frame_num),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .victim_found   (victim_found),
        .victim_frame   (victim_frame),
        .ring_size      (ring_size),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_in_ring (mem_wr_in_ring),
        .mem_wr_ref     (mem_wr_ref),
        .mem_wr_next    (mem_wr_next),
        .mem_wr_prev    (mem_wr_prev),
        .mem_rd_in_ring (mem_rd_in_ring),
        .mem_rd_ref     (mem_rd_ref),
        .mem_rd_next    (mem_rd_next),
        .mem_rd_prev    (mem_rd_prev)
    );

    // Frame table
    cpr_frame_mem #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .wr_en      (mem_wr_en),
        .wr_addr    (mem_wr_addr),
        .wr_in_ring (mem_wr_in_ring),
        .wr_ref     (mem_wr_ref),
        .wr_next    (mem_wr_next),
        .wr_prev    (mem_wr_prev),
        .rd_in_ring (mem_rd_in_ring),
        .rd_ref     (mem_rd_ref),
        .rd_next    (mem_rd_next),
        .rd_prev    (mem_rd_prev)
    );

endmodule : clock_page_replacer_top
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clock page replacer. A table of directed
// requests covers the empty ring, absent and repeated frames, the unused
// operation code and pins at the head, middle, tail and hand. Random bursts
// then follow: a hot set of a few frames, growth over all 64 frames, drains,
// and full fills followed by eviction sweeps. Each accepted request runs
// through a second-chance ring predictor. Every response is compared field
// by field with the oldest expected response. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import cpr_pkg::*;

    localparam int NUM_FRAMES   = NUM_FRAMES_DEF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * NUM_FRAMES + 16;
    localparam int N_DIRECTED   = 24;

    // Unused fourth operation code; the block must ignore it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic                   found;
        logic [FRAME_NUM_W-1:0] frame;
        logic [RING_SIZE_W-1:0] size;
    } replacer_rsp_t;

    typedef struct packed {
        logic [FUNC_W-1:0]      op;
        logic [FRAME_NUM_W-1:0] id;
        logic                   typed;
        logic                   found;
        logic [FRAME_NUM_W-1:0] frame;
        logic [RING_SIZE_W-1:0] size;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [FUNC_W-1:0]      func      = FUNC_VICTIM;
    logic [FRAME_NUM_W-1:0] frame_num = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic                   victim_found;
    logic [FRAME_NUM_W-1:0] victim_frame;
    logic [RING_SIZE_W-1:0] ring_size;

    // Predicted ring state
    bit                     ring_member [NUM_FRAMES];
    bit                     ref_flag    [NUM_FRAMES];
    logic [FRAME_NUM_W-1:0] link_next   [NUM_FRAMES];
    logic [FRAME_NUM_W-1:0] link_prev   [NUM_FRAMES];
    logic [FRAME_NUM_W-1:0] ring_head   = '0;
    logic [FRAME_NUM_W-1:0] ring_tail   = '0;
    logic [FRAME_NUM_W-1:0] hand        = '0;
    bit                     hand_parked = 1'b1;
    int                     ring_len    = 0;

    replacer_rsp_t pending_results [$];
    directed_row_t directed_rows [N_DIRECTED];

    int  error_count    = 0;
    int  sent_count     = 0;
    int  result_count   = 0;
    int  eviction_count = 0;
    int  peak_ring      = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  tx_quiet       = 1'b0;
    bit  rx_quiet       = 1'b0;

    clock_page_replacer_top #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .frame_num    (frame_num),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .victim_found (victim_found),
        .victim_frame (victim_frame),
        .ring_size    (ring_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draw an idle count: half the time none, else 1..12; none in quiet stretches
    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // Remove a frame from the ring; step the hand off it first
    task automatic unlink_frame(input int f);
        logic [FRAME_NUM_W-1:0] nx;
        logic [FRAME_NUM_W-1:0] pv;
        bit                     at_head;
        bit                     at_tail;
        nx      = link_next[f];
        pv      = link_prev[f];
        at_head = (ring_head == f);
        at_tail = (ring_tail == f);
        if (!hand_parked && hand == f)
        begin
            if (at_tail)
                hand_parked = 1'b1;
            else
                hand = nx;
        end
        if (at_head && at_tail)
        begin
            ring_head = '0;
            ring_tail = '0;
        end
        else if (at_head)
            ring_head = nx;
        else if (at_tail)
            ring_tail = pv;
        else
        begin
            link_next[pv] = nx;
            link_prev[nx] = pv;
        end
        ring_member[f] = 1'b0;
        ref_flag[f]    = 1'b0;
        if (ring_len > 0)
            ring_len--;
    endtask

    // Advance the second-chance ring by one request and form its response
    task automatic replace_step(input logic [FUNC_W-1:0] op,
                                input logic [FRAME_NUM_W-1:0] id,
                                output replacer_rsp_t rsp);
        int f;
        int sweep;
        rsp = '0;
        case (op)
            FUNC_VICTIM:
            begin
                if (ring_len != 0)
                begin
                    for (sweep = 0; sweep < 2 * NUM_FRAMES + 2 && !rsp.found; sweep++)
                    begin
                        if (hand_parked)
                        begin
                            hand        = ring_head;
                            hand_parked = 1'b0;
                        end
                        f = hand;
                        if (!ref_flag[f])
                        begin
                            rsp.found = 1'b1;
                            rsp.frame = FRAME_NUM_W'(f);
                            unlink_frame(f);
                        end
                        else
                        begin
                            ref_flag[f] = 1'b0;
                            if (ring_tail == f)
                                hand_parked = 1'b1;
                            else
                                hand = link_next[f];
                        end
                    end
                end
            end
            FUNC_PIN:
            begin
                if (ring_member[id])
                    unlink_frame(id);
            end
            FUNC_UNPIN:
            begin
                if (ring_member[id])
                    ref_flag[id] = 1'b1;
                else
                begin
                    if (ring_len == 0)
                        ring_head = id;
                    else
                    begin
                        link_next[ring_tail] = id;
                        link_prev[id]        = ring_tail;
                    end
                    ring_tail       = id;
                    ring_member[id] = 1'b1;
                    ref_flag[id]    = 1'b1;
                    ring_len++;
                end
            end
            default: ;
        endcase
        rsp.size = RING_SIZE_W'(ring_len);
    endtask

    // Offer one request after a random gap; predict it once accepted
    task automatic send_item(input logic [FUNC_W-1:0] op,
                             input logic [FRAME_NUM_W-1:0] id,
                             input bit typed,
                             input replacer_rsp_t typed_rsp);
        replacer_rsp_t predicted;
        int            gap;
        gap = draw_wait(tx_quiet);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= op;
        frame_num <= id;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        replace_step(op, id, predicted);
        pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
        sent_count++;
        if (predicted.found)
            eviction_count++;
        if (ring_len > peak_ring)
            peak_ring = ring_len;
    endtask

    // Check each response transaction and draw the stall for the next one
    always @(posedge clk)
    begin
        replacer_rsp_t want;
        if (rsp_valid && !rsp_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: response with none expected (found %0d frame %0d size %0d)",
                         $time, victim_found, victim_frame, ring_size);
            end
            else
            begin
                want = pending_results.pop_front();
                if (victim_found !== want.found)
                begin
                    error_count++;
                    $display("%0t: victim_found expected %0d got %0d",
                             $time, want.found, victim_found);
                end
                if (victim_frame !== want.frame)
                begin
                    error_count++;
                    $display("%0t: victim_frame expected %0d got %0d",
                             $time, want.frame, victim_frame);
                end
                if (ring_size !== want.size)
                begin
                    error_count++;
                    $display("%0t: ring_size expected %0d got %0d",
                             $time, want.size, ring_size);
                end
            end
            if (result_count % 64 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall_left = draw_wait(rx_quiet);
        end
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                     $time, cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int            i;
        int            k;
        int            pick;
        int            mode;
        int            random_sent;
        int            tmp;
        int            perm [NUM_FRAMES];
        logic [FUNC_W-1:0]      op;
        logic [FRAME_NUM_W-1:0] id;
        directed_row_t          row;

        // Empty-ring, absent-frame, unused-code and the opening unpin rows have fixed
        // answers; the rest follow the predictor
        directed_rows = '{
            '{FUNC_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
            '{FUNC_PIN,    6'd17, 1'b1, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNUSED, 6'd42, 1'b1, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd0,  1'b1, 1'b0, 6'd0, 7'd1},
            '{FUNC_UNPIN,  6'd63, 1'b1, 1'b0, 6'd0, 7'd2},
            '{FUNC_UNPIN,  6'd63, 1'b1, 1'b0, 6'd0, 7'd2},
            '{FUNC_UNPIN,  6'd21, 1'b1, 1'b0, 6'd0, 7'd3},
            '{FUNC_UNPIN,  6'd42, 1'b1, 1'b0, 6'd0, 7'd4},
            '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_PIN,    6'd63, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd21, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd42, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_PIN,    6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_PIN,    6'd21, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd63, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_PIN,    6'd42, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_VICTIM, 6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNUSED, 6'd0,  1'b1, 1'b0, 6'd0, 7'd0},
            '{FUNC_UNPIN,  6'd63, 1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_VICTIM, 6'd0,  1'b0, 1'b0, 6'd0, 7'd0},
            '{FUNC_VICTIM, 6'd63, 1'b1, 1'b0, 6'd0, 7'd0}
        };

        // Hold reset, then release
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            send_item(row.op, row.id, row.typed, {row.found, row.frame, row.size});
        end

        // Random bursts, each with its own mix
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            mode     = $urandom_range(0, 3);
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (mode == 3)
            begin
                // Fill the ring with every frame in shuffled order, then evict
                for (k = 0; k < NUM_FRAMES; k++)
                    perm[k] = k;
                for (k = NUM_FRAMES - 1; k > 0; k--)
                begin
                    pick       = $urandom_range(0, k);
                    tmp        = perm[k];
                    perm[k]    = perm[pick];
                    perm[pick] = tmp;
                end
                for (k = 0; k < NUM_FRAMES; k++)
                    send_item(FUNC_UNPIN, FRAME_NUM_W'(perm[k]), 1'b0, '0);
                tmp = $urandom_range(2, 70);
                for (k = 0; k < tmp; k++)
                    send_item(FUNC_VICTIM, FRAME_NUM_W'($urandom_range(0, 63)), 1'b0, '0);
                random_sent += NUM_FRAMES + tmp;
            end
            else
            begin
                for (k = 0; k < 40; k++)
                begin
                    pick = $urandom_range(0, 99);
                    id   = FRAME_NUM_W'($urandom_range(0, 63));
                    case (mode)
                        0:
                        begin
                            // Half the requests go to a hot set of eight frames: frequent hits and re-pins
                            id = {id[5:3] & {3{pick[0]}}, id[2:0]};
                            op = (pick < 40) ? FUNC_UNPIN :
                                 (pick < 65) ? FUNC_PIN :
                                 (pick < 95) ? FUNC_VICTIM : FUNC_UNUSED;
                        end
                        1:
                            op = (pick < 70) ? FUNC_UNPIN :
                                 (pick < 80) ? FUNC_PIN :
                                 (pick < 97) ? FUNC_VICTIM : FUNC_UNUSED;
                        default:
                            op = (pick < 10) ? FUNC_UNPIN :
                                 (pick < 30) ? FUNC_PIN :
                                 (pick < 97) ? FUNC_VICTIM : FUNC_UNUSED;
                    endcase
                    send_item(op, id, 1'b0, '0);
                    if (op != FUNC_UNUSED)
                        random_sent++;
                end
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d responses: %0d evictions, peak ring %0d",
                 sent_count, result_count, eviction_count, peak_ring);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/cpr_pkg.sv
rtl/cpr_frame_mem.sv
rtl/cpr_ctrl.sv
rtl/clock_page_replacer_top.sv
tb/testbench.sv
